// File: rtl/pps_pkg.sv
// Package for the pure pursuit steering core: payload structs, CORDIC angle table
// and fixed constants. Used by pure_pursuit_steering_core; depends on nothing.
package pps_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SinGainQ15  = 19898;

  localparam logic [0:0] OpLoad = 1'b0;
  localparam logic [0:0] OpPose = 1'b1;

  localparam logic [1:0] RegWheelbase = 2'd0;
  localparam logic [1:0] RegLookahead = 2'd1;
  localparam logic [1:0] RegGoalDist  = 2'd2;

  typedef struct packed {
    logic               op;
    logic        [3:0]  point_index;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] vehicle_x;
    logic signed [19:0] vehicle_y;
    logic signed [15:0] vehicle_yaw;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic        [3:0]  target_index;
    logic        [3:0]  nearest_index;
    logic               goal_reached;
  } out_item_t;

  function automatic logic [13:0] atan_entry(input logic [3:0] i);
    logic [13:0] r;
    begin
      case (i)
        4'd0:    r = 14'd8192;
        4'd1:    r = 14'd4836;
        4'd2:    r = 14'd2555;
        4'd3:    r = 14'd1297;
        4'd4:    r = 14'd651;
        4'd5:    r = 14'd326;
        4'd6:    r = 14'd163;
        4'd7:    r = 14'd81;
        4'd8:    r = 14'd41;
        4'd9:    r = 14'd20;
        4'd10:   r = 14'd10;
        4'd11:   r = 14'd5;
        4'd12:   r = 14'd3;
        4'd13:   r = 14'd1;
        4'd14:   r = 14'd1;
        default: r = 14'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/pure_pursuit_steering_core.sv
// Pure pursuit steering core: path point store, nearest and target search, CORDIC steering.
// Depends on pps_pkg.
//
// A load transfer writes one path point and gives no result. A pose transfer runs a
// sequencer around one shared squared-distance unit and one shared CORDIC stage (16
// iterations per angle, used three times). The nearest walk evaluates at least two points
// and the target search at least one. busy is high throughout a pose and the next transfer
// can be taken in the cycle the result is shown. The result appears for one cycle on
// result_valid_o and cannot be held off by the receiver.
module pure_pursuit_steering_core #(
  parameter int unsigned PathPoints = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pps_pkg::in_item_t  in_item_i,
  output logic               result_valid_o,
  output pps_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned IdxW = $clog2(PathPoints);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PathPoints - 1);
  localparam logic [IdxW-1:0] PenIdx  = IdxW'(PathPoints - 2);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDist   = 4'd1;
  localparam logic [3:0] StDsum   = 4'd2;
  localparam logic [3:0] StTgtPre = 4'd3;
  localparam logic [3:0] StBear   = 4'd4;
  localparam logic [3:0] StSin    = 4'd5;
  localparam logic [3:0] StMul    = 4'd6;
  localparam logic [3:0] StSteer  = 4'd7;
  localparam logic [3:0] StOut    = 4'd8;
  localparam logic [3:0] StSinPre = 4'd9;

  localparam logic [1:0] PhWalk0 = 2'd0;
  localparam logic [1:0] PhWalk  = 2'd1;
  localparam logic [1:0] PhTgt   = 2'd2;
  localparam logic [1:0] PhGoal  = 2'd3;

  logic [11:0] wheelbase_q;
  logic [15:0] lookahead_q, goal_q;
  logic signed [19:0] north_q [PathPoints];
  logic signed [19:0] east_q  [PathPoints];
  logic [IdxW-1:0] nearest_q;

  logic [3:0]  st_q;
  logic [1:0]  ph_q;
  logic [IdxW-1:0] ind_q, tgt_q, pt_q;
  logic signed [19:0] vx_q, vy_q;
  logic signed [15:0] yaw_q;
  logic signed [41:0] sqx_q, sqy_q;
  logic [42:0] dthis_q;
  logic        goal_hit_q;
  logic [3:0]  it_q;
  logic signed [36:0] cx_q, cy_q;
  logic signed [17:0] cz_q;
  logic        vec_q, neg_q;
  logic        bzero_q;

  logic signed [20:0] dx, dy;
  logic [42:0] dsum;
  logic signed [36:0] xs, ys;
  logic        dir;
  logic signed [17:0] at;
  logic [31:0] la_sq, gd_sq;

  assign busy = (st_q != StIdle);
  assign dx = 21'(vx_q) - 21'(north_q[pt_q]);
  assign dy = 21'(vy_q) - 21'(east_q[pt_q]);
  assign dsum = 43'(unsigned'(sqx_q)) + 43'(unsigned'(sqy_q));
  assign xs = cx_q >>> it_q;
  assign ys = cy_q >>> it_q;
  assign dir = vec_q ? ~cy_q[36] : ~cz_q[17];
  assign at = 18'(pps_pkg::atan_entry(it_q));
  assign la_sq = lookahead_q * lookahead_q;
  assign gd_sq = goal_q * goal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q <= 12'd260;
      lookahead_q <= 16'd1000;
      goal_q      <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pps_pkg::RegWheelbase: wheelbase_q <= cfg_data_i[11:0];
        pps_pkg::RegLookahead: lookahead_q <= cfg_data_i;
        pps_pkg::RegGoalDist:  goal_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy && in_item_i.op == pps_pkg::OpLoad &&
        32'(in_item_i.point_index) < PathPoints) begin
      north_q[IdxW'(in_item_i.point_index)] <= in_item_i.point_x;
      east_q[IdxW'(in_item_i.point_index)]  <= in_item_i.point_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      nearest_q <= '0;
      result_valid_o <= 1'b0;
      result_o <= '0;
      ph_q <= PhWalk0;
      ind_q <= '0;
      tgt_q <= '0;
      pt_q <= '0;
      sqx_q <= '0;
      sqy_q <= '0;
      dthis_q <= '0;
      goal_hit_q <= 1'b0;
      it_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      vec_q <= 1'b0;
      neg_q <= 1'b0;
      bzero_q <= 1'b0;
    end else begin
      result_valid_o <= (st_q == StOut);
      unique case (st_q) inside
        StIdle: begin
          if (start) begin
            if (in_item_i.op == pps_pkg::OpLoad) begin
              if (in_item_i.point_index == 4'd0) nearest_q <= '0;
            end else begin
              st_q <= StDist;
              ph_q <= PhWalk0;
              ind_q <= (nearest_q > PenIdx) ? PenIdx : nearest_q;
              pt_q  <= (nearest_q > PenIdx) ? PenIdx : nearest_q;
            end
          end
        end
        StDist: begin
          sqx_q <= 42'(dx * dx);
          sqy_q <= 42'(dy * dy);
          st_q <= StDsum;
        end
        StDsum: begin
          st_q <= StDist;
          unique case (ph_q)
            PhWalk0: begin
              dthis_q <= dsum;
              ph_q <= PhWalk;
              pt_q <= ind_q + 1'b1;
            end
            PhWalk: begin
              if (dthis_q < dsum) begin
                st_q <= StTgtPre;
              end else begin
                dthis_q <= dsum;
                if (pt_q == LastIdx) begin
                  st_q <= StTgtPre;
                end else begin
                  ind_q <= pt_q;
                  pt_q <= pt_q + 1'b1;
                end
              end
            end
            PhTgt: begin
              if (43'(la_sq) > dsum) begin
                if (pt_q != LastIdx) begin
                  pt_q <= pt_q + 1'b1;
                end else begin
                  tgt_q <= pt_q;
                  ph_q <= PhGoal;
                  pt_q <= LastIdx;
                end
              end else begin
                tgt_q <= pt_q;
                ph_q <= PhGoal;
                pt_q <= LastIdx;
              end
            end
            PhGoal: begin
              goal_hit_q <= dsum < 43'(gd_sq);
              st_q <= StBear;
              it_q <= '0;
              vec_q <= 1'b1;
              begin : bear_init
                logic signed [20:0] bx, by;
                bx = 21'(north_q[tgt_q]) - 21'(vx_q);
                by = 21'(east_q[tgt_q]) - 21'(vy_q);
                neg_q <= bx[20];
                bzero_q <= (bx == 21'sd0 && by == 21'sd0);
                cx_q <= bx[20] ? -37'(bx) : 37'(bx);
                cy_q <= bx[20] ? -37'(by) : 37'(by);
                cz_q <= '0;
              end
            end
            default: ;
          endcase
        end
        StTgtPre: begin
          nearest_q <= ind_q;
          pt_q <= ind_q;
          ph_q <= PhTgt;
          st_q <= StDist;
        end
        StBear, StSin, StSteer: begin
          if (dir ^ vec_q) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - at;
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + at;
          end
          it_q <= it_q + 1'b1;
          if (it_q == 4'(pps_pkg::CordicSteps - 1)) begin
            if (st_q == StBear) st_q <= StSinPre;
            else if (st_q == StSin) st_q <= StMul;
            else st_q <= StOut;
          end
        end
        StSinPre: begin
          begin : sin_init
            logic signed [15:0] bear, alpha;
            logic signed [17:0] z;
            logic nz;
            bear = bzero_q ? 16'sd0 : cz_q[15:0] + (neg_q ? 16'sh8000 : 16'sd0);
            alpha = bear - yaw_q;
            z = 18'(alpha);
            nz = 1'b0;
            if (z > 18'sd16384) begin
              z = z - 18'sd32768;
              nz = 1'b1;
            end else if (z < -18'sd16384) begin
              z = z + 18'sd32768;
              nz = 1'b1;
            end
            neg_q <= nz;
            cz_q <= z;
          end
          cx_q <= 37'(pps_pkg::SinGainQ15);
          cy_q <= '0;
          vec_q <= 1'b0;
          it_q <= '0;
          st_q <= StSin;
        end
        StMul: begin
          begin : mul_init
            logic signed [36:0] r;
            logic signed [29:0] prod;
            r = neg_q ? -cy_q : cy_q;
            if (r > 37'sd32768) r = 37'sd32768;
            if (r < -37'sd32768) r = -37'sd32768;
            prod = $signed(r[16:0]) * $signed({1'b0, wheelbase_q});
            cy_q <= 37'(prod) <<< 1;
            cx_q <= 37'({lookahead_q, 15'd0});
            cz_q <= '0;
            vec_q <= 1'b1;
            it_q <= '0;
          end
          st_q <= StSteer;
        end
        StOut: begin
          if (lookahead_q == 16'd0 && cx_q == 37'sd0 && cy_q == 37'sd0)
            result_o.steer_angle <= '0;
          else if (cz_q > 18'sd16384) result_o.steer_angle <= 16'sd16384;
          else if (cz_q < -18'sd16384) result_o.steer_angle <= -16'sd16384;
          else result_o.steer_angle <= cz_q[15:0];
          result_o.target_index  <= 4'(tgt_q);
          result_o.nearest_index <= 4'(nearest_q);
          result_o.goal_reached  <= goal_hit_q;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy && in_item_i.op == pps_pkg::OpPose) begin
      vx_q <= in_item_i.vehicle_x;
      vy_q <= in_item_i.vehicle_y;
      yaw_q <= in_item_i.vehicle_yaw;
    end
  end

endmodule
